// ===== hdl/double_level_background_model_assert.svh =====
// Assertion macros used by the checker of the background model.
`ifndef DOUBLE_LEVEL_BACKGROUND_MODEL_ASSERT_SVH
`define DOUBLE_LEVEL_BACKGROUND_MODEL_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define DLBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("background model check failed");

// Next-cycle implication, ignored while reset is high.
`define DLBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("background model check failed");

// Same-cycle implication that also holds around reset.
`define DLBM_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("background model check failed");

`endif

// ===== hdl/dlbm_pkg.sv =====
// Types, constants and pixel arithmetic of the background model.
package dlbm_pkg;

  localparam int PIXELS      = 65536;
  localparam int CHANNELS    = 3;
  localparam int IDX_W       = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int HOLD_W      = 8;
  localparam int SUM_W       = 17;
  localparam int ALPHA_W     = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SUM_W-1:0]   SUM_MAX      = '1;
  localparam logic [ALPHA_W-1:0] QUICK_WEIGHT = ALPHA_W'(20);
  localparam logic [ALPHA_W-1:0] ALPHA_FULL   = ALPHA_W'(256);
  localparam logic [IDX_W-1:0]   LAST_INDEX   = IDX_W'(PIXELS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_DIFF_THR = 3'd0,
    CFG_BG_THR         = 3'd1,
    CFG_STABLE_FRAMES  = 3'd2,
    CFG_QUICK_COUNT    = 3'd3,
    CFG_ALPHA          = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0]    frame_diff_thr;
    logic [CH_W-1:0]    bg_thr;
    logic [HOLD_W-1:0]  stable_frames;
    logic [SUM_W-1:0]   quick_count;
    logic [ALPHA_W-1:0] alpha;
  } cfg_t;

  typedef enum logic {
    OP_PIXEL  = 1'b0,
    OP_UPDATE = 1'b1
  } op_kind_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    op_kind_t         kind;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
    logic             frame_end;
    logic             seed;
    logic             last;
  } op_t;

  function automatic logic [CH_W-1:0] max_diff(logic [PIX_W-1:0] p, logic [PIX_W-1:0] q);
    logic [CH_W-1:0] m;
    logic [CH_W-1:0] d;
    m = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      d = (p[c*CH_W +: CH_W] > q[c*CH_W +: CH_W]) ?
          p[c*CH_W +: CH_W] - q[c*CH_W +: CH_W] :
          q[c*CH_W +: CH_W] - p[c*CH_W +: CH_W];
      if (d > m) m = d;
    end
    return m;
  endfunction

  // floor((a*cur + (256-a)*bg) / 256) on the used channels, a clipped at 256.
  function automatic logic [PIX_W-1:0] blend(logic [PIX_W-1:0] bg, logic [PIX_W-1:0] cur,
                                             logic [ALPHA_W-1:0] a);
    logic [ALPHA_W-1:0] w;
    logic [ALPHA_W-1:0] iw;
    logic [16:0]        acc;
    logic [PIX_W-1:0]   r;
    r   = bg;
    w   = (a > ALPHA_FULL) ? ALPHA_FULL : a;
    iw  = ALPHA_FULL - w;
    for (int c = 0; c < CHANNELS; c++) begin
      acc = {8'b0, w} * {9'b0, cur[c*CH_W +: CH_W]} + {8'b0, iw} * {9'b0, bg[c*CH_W +: CH_W]};
      r[c*CH_W +: CH_W] = acc[15:8];
    end
    return r;
  endfunction

endpackage

// ===== hdl/dlbm_item_if.sv =====
// Input channel of the background model: one pixel or update item.
interface dlbm_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  logic       frame_end;

  modport source (output valid, func, chan_a, chan_b, chan_c, frame_end, input ready);
  modport sink   (input valid, func, chan_a, chan_b, chan_c, frame_end, output ready);
endinterface

// ===== hdl/dlbm_result_if.sv =====
// Output channel of the background model: one segmentation result item.
interface dlbm_result_if;
  logic valid;
  logic ready;
  logic foreground;
  logic quick_frame;
  logic last;

  modport source (output valid, foreground, quick_frame, last, input ready);
  modport sink   (input valid, foreground, quick_frame, last, output ready);
endinterface

// ===== hdl/dlbm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module dlbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== hdl/dlbm_front.sv =====
// Front end: accepts items, assigns pixel addresses and frame marks.
module dlbm_front (
  input  logic            clk,
  input  logic            rst,
  dlbm_item_if.sink       items,
  input  logic            accept_ok,
  output logic            push,
  output dlbm_pkg::op_t   op
);
  import dlbm_pkg::*;

  logic [IDX_W-1:0] pixel_index;
  logic [IDX_W-1:0] step_index;
  logic [IDX_W-1:0] last_idx;
  logic             seeded;
  logic             step_last;

  assign items.ready = accept_ok;
  assign push        = items.valid && accept_ok;
  assign step_last   = (step_index == last_idx);

  always_comb begin
    op.kind      = items.func ? OP_UPDATE : OP_PIXEL;
    op.idx       = items.func ? step_index : pixel_index;
    op.pix       = {items.chan_c, items.chan_b, items.chan_a};
    op.frame_end = !items.func && items.frame_end;
    op.seed      = !seeded;
    op.last      = items.func && step_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index <= '0;
      step_index  <= '0;
      last_idx    <= LAST_INDEX;
      seeded      <= 1'b0;
    end else if (push) begin
      if (!items.func) begin
        if (items.frame_end) begin
          last_idx    <= pixel_index;
          seeded      <= 1'b1;
          pixel_index <= '0;
          step_index  <= '0;
        end else if (pixel_index == LAST_INDEX) begin
          pixel_index <= '0;
        end else begin
          pixel_index <= pixel_index + 1'b1;
        end
      end else begin
        step_index <= step_last ? '0 : step_index + 1'b1;
      end
    end
  end
endmodule

// ===== hdl/dlbm_queue.sv =====
// Short FIFO of classified items between the front and the back.
module dlbm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dlbm_pkg::op_t push_op,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output dlbm_pkg::op_t head
);
  import dlbm_pkg::*;

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end
endmodule

// ===== hdl/dlbm_back.sv =====
// Back end: per-pixel memories, motion detection, background update and result.
module dlbm_back (
  input  logic            clk,
  input  logic            rst,
  input  dlbm_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  dlbm_pkg::op_t   q_head,
  output logic            q_pop,
  output logic            clearing,
  dlbm_result_if.source   results
);
  import dlbm_pkg::*;

  logic             s1_valid;
  op_t              s1_op;
  logic             s1_fire;
  logic             load;
  logic [IDX_W-1:0] clr_addr;

  logic [SUM_W-1:0]  motion_sum;
  logic [HOLD_W-1:0] quiet_countdown;
  logic              quick_now;

  logic [PIX_W-1:0]  prev_q, bg_q, prev_rd, bg_rd;
  logic [HOLD_W-1:0] hold_q, hold_rd;
  logic              mot_q, mot_rd;

  logic              prev_we, bg_we, hold_we, mot_we;
  logic [PIX_W-1:0]  prev_wd, bg_wd;
  logic [HOLD_W-1:0] hold_wd;
  logic              mot_wd;
  logic              hold_ram_we;
  logic [IDX_W-1:0]  hold_ram_addr;
  logic [HOLD_W-1:0] hold_ram_wd;

  // Most recent write of each memory, for reads issued in the same cycle.
  logic              fw_prev_valid, fw_bg_valid, fw_hold_valid, fw_mot_valid;
  logic [IDX_W-1:0]  fw_prev_addr, fw_bg_addr, fw_hold_addr, fw_mot_addr;
  logic [PIX_W-1:0]  fw_prev_data, fw_bg_data;
  logic [HOLD_W-1:0] fw_hold_data;
  logic              fw_mot_data;

  logic              mv;
  logic [SUM_W-1:0]  sum_next;
  logic [PIX_W-1:0]  bg_new;
  logic              fg;

  assign s1_fire = s1_valid &&
                   (s1_op.kind == OP_PIXEL || !results.valid || results.ready);
  assign load    = q_valid && !clearing && (!s1_valid || s1_fire);
  assign q_pop   = load;

  assign hold_ram_we   = clearing || hold_we;
  assign hold_ram_addr = clearing ? clr_addr : s1_op.idx;
  assign hold_ram_wd   = clearing ? '0 : hold_wd;

  dlbm_ram #(.WIDTH(PIX_W), .DEPTH(PIXELS)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(s1_op.idx), .wdata(prev_wd),
    .re(load), .raddr(q_head.idx), .rdata(prev_q)
  );
  dlbm_ram #(.WIDTH(PIX_W), .DEPTH(PIXELS)) u_bg_ram (
    .clk(clk), .we(bg_we), .waddr(s1_op.idx), .wdata(bg_wd),
    .re(load), .raddr(q_head.idx), .rdata(bg_q)
  );
  dlbm_ram #(.WIDTH(HOLD_W), .DEPTH(PIXELS)) u_hold_ram (
    .clk(clk), .we(hold_ram_we), .waddr(hold_ram_addr), .wdata(hold_ram_wd),
    .re(load), .raddr(q_head.idx), .rdata(hold_q)
  );
  dlbm_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_mot_ram (
    .clk(clk), .we(mot_we), .waddr(s1_op.idx), .wdata(mot_wd),
    .re(load), .raddr(q_head.idx), .rdata(mot_q)
  );

  always_comb begin
    prev_rd = (fw_prev_valid && fw_prev_addr == s1_op.idx) ? fw_prev_data : prev_q;
    bg_rd   = (fw_bg_valid && fw_bg_addr == s1_op.idx) ? fw_bg_data : bg_q;
    hold_rd = (fw_hold_valid && fw_hold_addr == s1_op.idx) ? fw_hold_data : hold_q;
    mot_rd  = (fw_mot_valid && fw_mot_addr == s1_op.idx) ? fw_mot_data : mot_q;
  end

  always_comb begin
    mv       = (max_diff(s1_op.pix, prev_rd) > cfg.frame_diff_thr);
    sum_next = motion_sum;
    if (!s1_op.seed && mv && motion_sum != SUM_MAX) sum_next = motion_sum + 1'b1;

    prev_we = 1'b0;
    prev_wd = s1_op.pix;
    bg_we   = 1'b0;
    bg_wd   = s1_op.pix;
    hold_we = 1'b0;
    hold_wd = cfg.stable_frames;
    mot_we  = 1'b0;
    mot_wd  = !s1_op.seed && mv;
    bg_new  = bg_rd;

    if (s1_op.kind == OP_PIXEL) begin
      prev_we = s1_fire;
      mot_we  = s1_fire;
      bg_we   = s1_fire && s1_op.seed;
    end else begin
      if (quick_now) begin
        bg_new = blend(bg_rd, prev_rd, QUICK_WEIGHT);
        bg_we  = s1_fire;
      end else if (mot_rd) begin
        hold_we = s1_fire;
      end else if (hold_rd != '0) begin
        hold_wd = hold_rd - 1'b1;
        hold_we = s1_fire;
      end else begin
        bg_new = blend(bg_rd, prev_rd, cfg.alpha);
        bg_we  = s1_fire;
      end
      bg_wd = bg_new;
    end
    fg = (max_diff(prev_rd, bg_new) > cfg.bg_thr);
  end

  always_ff @(posedge clk) begin
    if (load) s1_op <= q_head;
    if (s1_fire && s1_op.kind == OP_UPDATE) begin
      results.foreground  <= fg;
      results.quick_frame <= quick_now;
      results.last        <= s1_op.last;
    end
    if (prev_we) begin
      fw_prev_addr <= s1_op.idx;
      fw_prev_data <= prev_wd;
    end
    if (bg_we) begin
      fw_bg_addr <= s1_op.idx;
      fw_bg_data <= bg_wd;
    end
    if (hold_we) begin
      fw_hold_addr <= s1_op.idx;
      fw_hold_data <= hold_wd;
    end
    if (mot_we) begin
      fw_mot_addr <= s1_op.idx;
      fw_mot_data <= mot_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      results.valid   <= 1'b0;
      clearing        <= 1'b1;
      clr_addr        <= '0;
      motion_sum      <= '0;
      quiet_countdown <= HOLD_W'(40);
      quick_now       <= 1'b0;
      fw_prev_valid   <= 1'b0;
      fw_bg_valid     <= 1'b0;
      fw_hold_valid   <= 1'b0;
      fw_mot_valid    <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == LAST_INDEX) clearing <= 1'b0;
        else clr_addr <= clr_addr + 1'b1;
      end
      if (load) s1_valid <= 1'b1;
      else if (s1_fire) s1_valid <= 1'b0;

      if (s1_fire && s1_op.kind == OP_UPDATE) results.valid <= 1'b1;
      else if (results.ready) results.valid <= 1'b0;

      if (prev_we) fw_prev_valid <= 1'b1;
      if (bg_we)   fw_bg_valid   <= 1'b1;
      if (hold_we) fw_hold_valid <= 1'b1;
      if (mot_we)  fw_mot_valid  <= 1'b1;

      if (s1_fire && s1_op.kind == OP_PIXEL) begin
        if (s1_op.frame_end) begin
          motion_sum <= '0;
          if (s1_op.seed) begin
            quick_now <= 1'b0;
          end else if (sum_next < cfg.quick_count) begin
            if (quiet_countdown != '0) begin
              quiet_countdown <= quiet_countdown - 1'b1;
              quick_now       <= 1'b0;
            end else begin
              quiet_countdown <= cfg.stable_frames;
              quick_now       <= 1'b1;
            end
          end else begin
            quiet_countdown <= cfg.stable_frames;
            quick_now       <= 1'b0;
          end
        end else begin
          motion_sum <= sum_next;
        end
      end
    end
  end
endmodule

// ===== hdl/double_level_background_model.sv =====
// Top level of the double level background model.
// Per-pixel background model for a raster pixel stream. Pixel items (func 0)
// store a frame; the first frame after reset seeds the background, and every
// later frame marks moving pixels against the previous frame and counts them.
// Update items (func 1), one per stored pixel in raster order, then update the
// background (hold counters, slow blend at alpha/256, or a whole-frame blend
// at 20/256 on a quiet frame once the quiet countdown has run out) and return
// one result item each with the foreground bit. Pixel items return nothing.
// Throughput is one item per clock cycle in any mix of pixel and update items
// while the result output is not held back; each item costs one read and
// one write of the per-pixel memories, and back-to-back items on the same
// pixel are served by write forwarding. An update item waits in the queue,
// is then read from the memories into the stage register, and its result
// is then computed into the output register. After reset the block clears
// its hold counters, one per cycle, and accepts no item until all 65536 are
// cleared; configuration writes are taken during that time.
// Configuration is meant to be written only while no item is in flight.
module double_level_background_model (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dlbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlbm_pkg::CFG_DATA_W-1:0] cfg_data,
  dlbm_item_if.sink                       items,
  dlbm_result_if.source                   results
);
  import dlbm_pkg::*;

  cfg_t cfg;
  logic push;
  op_t  push_op;
  logic q_full;
  logic q_valid;
  op_t  q_head;
  logic q_pop;
  logic clearing;

  // Configuration registers, written by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_diff_thr <= CH_W'(5);
      cfg.bg_thr         <= CH_W'(25);
      cfg.stable_frames  <= HOLD_W'(40);
      cfg.quick_count    <= '0;
      cfg.alpha          <= ALPHA_W'(20);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_DIFF_THR: cfg.frame_diff_thr <= cfg_data[CH_W-1:0];
        CFG_BG_THR:         cfg.bg_thr         <= cfg_data[CH_W-1:0];
        CFG_STABLE_FRAMES:  cfg.stable_frames  <= cfg_data[HOLD_W-1:0];
        CFG_QUICK_COUNT:    cfg.quick_count    <= cfg_data[SUM_W-1:0];
        CFG_ALPHA:          cfg.alpha          <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // The front takes an item whenever the queue has room and the clear is done.
  dlbm_front u_front (
    .clk(clk), .rst(rst), .items(items),
    .accept_ok(!q_full && !clearing),
    .push(push), .op(push_op)
  );

  dlbm_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_op(push_op), .pop(q_pop),
    .full(q_full), .head_valid(q_valid), .head(q_head)
  );

  dlbm_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .clearing(clearing), .results(results)
  );
endmodule

// ===== hdl/dlbm_checker.sv =====
// Port-level checks of the background model and their binding.
`include "double_level_background_model_assert.svh"

module dlbm_checker (
  input logic           clk,
  input logic           rst,
  dlbm_item_if.sink     items,
  dlbm_result_if.source results
);
  // A result waiting to be taken stays offered.
  `DLBM_ASSERT_NEXT(a_result_held, results.valid && !results.ready, results.valid)
  // Its fields do not change while it waits.
  `DLBM_ASSERT_NEXT(a_result_stable, results.valid && !results.ready, $stable(results.foreground) && $stable(results.quick_frame) && $stable(results.last))
  // The memory clear after reset keeps the input closed.
  `DLBM_ASSERT_ALWAYS(a_clear_closed, $past(rst), !items.ready)
  // Nothing comes out right after reset.
  `DLBM_ASSERT_ALWAYS(a_clear_quiet, $past(rst), !results.valid)
endmodule

bind double_level_background_model dlbm_checker u_dlbm_checker (
  .clk(clk), .rst(rst), .items(items), .results(results)
);
